>>> design/clf_pkg.sv
package clf_pkg;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_UPLOAD,
      PHASE_DOWNLOAD
   } phase_type;

   typedef enum logic {
      FMT_FRAME,
      FMT_SINGLE
   } format_type;

   localparam logic [1:0] MODE_COMMAND = 2'd0;
   localparam logic [1:0] MODE_UPLOAD  = 2'd1;
   localparam logic [1:0] MODE_NIBBLE  = 2'd2;

   localparam logic [1:0] KIND_LINK    = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_VERDICT = 2'd2;

   localparam logic [7:0] SYNC_FIRST  = 8'hD5;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [7:0] SYNC_THIRD  = 8'h96;
   localparam logic [7:0] CHECK_SEED  = 8'h81;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   localparam logic [7:0] CMD_UPLOAD_A   = 8'h00;
   localparam logic [7:0] CMD_DOWNLOAD_A = 8'h01;
   localparam logic [7:0] CMD_UPLOAD_B   = 8'h02;
   localparam logic [7:0] CMD_DOWNLOAD_B = 8'h03;

   typedef logic [3:0] count_type;

   localparam count_type FRAME_COUNT       = 4'd9;
   localparam count_type FRAME_CHECK_COUNT = 4'd10;
   localparam count_type SINGLE_COUNT      = 4'd1;
   localparam count_type PAIR_COUNT        = 4'd2;

   typedef struct packed {
      format_type  format;
      logic [7:0]  code;
      logic [15:0] address;
      logic [15:0] length;
      logic [7:0]  head_check;
      logic [7:0]  first_byte;
      logic [7:0]  extra_byte;
      count_type   count;
      logic [1:0]  kind;
      logic        match;
   } desc_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } load_type;

endpackage

>>> design/copier_link_command_framer_unit.sv
// Host-side framer for the copier serial link. Each accepted transaction is
// processed in the cycle it is taken, and the results it causes leave one per
// cycle from the output register while rsp_ready allows: a command gives a
// nine-byte frame (ten for an upload of zero length), an upload byte one or
// two results, and a nibble pair one result. A new transaction is taken in
// every cycle while the previous one has at most one result left and that one
// is handed over, so unstalled single-result traffic runs at one transaction
// per cycle and a command holds the input until its last frame byte goes out.
// Transactions that fit no pending transfer are taken and give no result.
module copier_link_command_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_code,
   input  logic [15:0] req_address,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_kind,
   output logic        rsp_match,
   output logic        rsp_last
);

   clf_pkg::load_type load;
   logic              accept;

   assign accept = req_valid && req_ready;

   clf_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .mode    (req_mode),
      .code    (req_code),
      .address (req_address),
      .length  (req_length),
      .value   (req_value),
      .load    (load)
   );

   clf_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .load_ready   (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_match    (rsp_match),
      .rsp_last     (rsp_last)
   );

endmodule

>>> design/clf_core.sv
module clf_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          mode,
   input  logic [7:0]          code,
   input  logic [15:0]         address,
   input  logic [15:0]         length,
   input  logic [7:0]          value,
   output clf_pkg::load_type   load
);

   clf_pkg::phase_type phase_ff, phase_in;
   logic [15:0]        remaining_ff, remaining_in;
   logic [7:0]         check_ff, check_in;
   logic [3:0]         held_ff, held_in;
   logic               waiting_ff, waiting_in;

   clf_pkg::desc_type  desc;
   logic               has_result;
   logic [15:0]        rem_dec;
   logic [7:0]         paired;
   logic [7:0]         up_check;
   logic               is_upload;
   logic               is_download;

   assign rem_dec  = remaining_ff - 16'd1;
   assign paired   = {value[3:0] & clf_pkg::NIBBLE_MASK, held_ff};
   assign up_check = check_ff ^ value;
   assign is_upload   = (code == clf_pkg::CMD_UPLOAD_A) || (code == clf_pkg::CMD_UPLOAD_B);
   assign is_download = (code == clf_pkg::CMD_DOWNLOAD_A) || (code == clf_pkg::CMD_DOWNLOAD_B);

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      check_in     = check_ff;
      held_in      = held_ff;
      waiting_in   = waiting_ff;
      has_result   = 1'b0;

      desc.format     = clf_pkg::FMT_SINGLE;
      desc.code       = code;
      desc.address    = address;
      desc.length     = length;
      desc.head_check = clf_pkg::CHECK_SEED ^ code ^ address[7:0] ^ address[15:8]
                        ^ length[7:0] ^ length[15:8];
      desc.first_byte = value;
      desc.extra_byte = clf_pkg::CHECK_SEED;
      desc.count      = clf_pkg::SINGLE_COUNT;
      desc.kind       = clf_pkg::KIND_LINK;
      desc.match      = 1'b0;

      case (mode)
         clf_pkg::MODE_COMMAND: begin
            has_result   = 1'b1;
            desc.format  = clf_pkg::FMT_FRAME;
            desc.count   = clf_pkg::FRAME_COUNT;
            check_in     = clf_pkg::CHECK_SEED;
            remaining_in = length;
            held_in      = '0;
            waiting_in   = 1'b0;
            if (is_upload) begin
               if (length == 16'd0) begin
                  desc.count = clf_pkg::FRAME_CHECK_COUNT;
                  phase_in   = clf_pkg::PHASE_IDLE;
               end else begin
                  phase_in = clf_pkg::PHASE_UPLOAD;
               end
            end else if (is_download) begin
               phase_in = clf_pkg::PHASE_DOWNLOAD;
            end else begin
               phase_in     = clf_pkg::PHASE_IDLE;
               remaining_in = '0;
            end
         end
         clf_pkg::MODE_UPLOAD: begin
            if (phase_ff == clf_pkg::PHASE_UPLOAD && remaining_ff != 16'd0) begin
               has_result      = 1'b1;
               desc.first_byte = value;
               desc.extra_byte = up_check;
               check_in        = up_check;
               remaining_in    = rem_dec;
               if (rem_dec == 16'd0) begin
                  desc.count = clf_pkg::PAIR_COUNT;
                  phase_in   = clf_pkg::PHASE_IDLE;
                  check_in   = clf_pkg::CHECK_SEED;
               end
            end
         end
         clf_pkg::MODE_NIBBLE: begin
            if (phase_ff == clf_pkg::PHASE_DOWNLOAD) begin
               if (!waiting_ff) begin
                  held_in    = value[3:0] & clf_pkg::NIBBLE_MASK;
                  waiting_in = 1'b1;
               end else begin
                  has_result      = 1'b1;
                  waiting_in      = 1'b0;
                  held_in         = '0;
                  desc.first_byte = paired;
                  if (remaining_ff != 16'd0) begin
                     desc.kind    = clf_pkg::KIND_DATA;
                     check_in     = check_ff ^ paired;
                     remaining_in = rem_dec;
                  end else begin
                     desc.kind  = clf_pkg::KIND_VERDICT;
                     desc.match = (paired == check_ff);
                     phase_in   = clf_pkg::PHASE_IDLE;
                     check_in   = clf_pkg::CHECK_SEED;
                  end
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= clf_pkg::PHASE_IDLE;
         remaining_ff <= '0;
         check_ff     <= clf_pkg::CHECK_SEED;
         held_ff      <= '0;
         waiting_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         check_ff     <= check_in;
         held_ff      <= held_in;
         waiting_ff   <= waiting_in;
      end
   end

   assign load.valid = accept && has_result;
   assign load.desc  = desc;

endmodule

>>> design/clf_emit.sv
module clf_emit (
   input  logic              clock,
   input  logic              reset,
   input  clf_pkg::load_type load,
   output logic              load_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic [1:0]        rsp_kind,
   output logic              rsp_match,
   output logic              rsp_last
);

   clf_pkg::desc_type  desc_ff;
   logic               slot_valid_ff;
   clf_pkg::count_type idx_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [1:0]         rsp_kind_ff;
   logic               rsp_match_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               advance;
   logic               at_last;

   function automatic logic [7:0] frame_byte(input clf_pkg::desc_type d,
                                             input clf_pkg::count_type i);
      logic [7:0] b;
      case (i)
         4'd0:    b = clf_pkg::SYNC_FIRST;
         4'd1:    b = clf_pkg::SYNC_SECOND;
         4'd2:    b = clf_pkg::SYNC_THIRD;
         4'd3:    b = d.code;
         4'd4:    b = d.address[7:0];
         4'd5:    b = d.address[15:8];
         4'd6:    b = d.length[7:0];
         4'd7:    b = d.length[15:8];
         4'd8:    b = d.head_check;
         default: b = d.extra_byte;
      endcase
      return b;
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign advance    = slot_valid_ff && out_free;
   assign at_last    = (idx_ff == desc_ff.count - clf_pkg::SINGLE_COUNT);
   assign load_ready = !slot_valid_ff || (advance && at_last);

   always_comb begin
      case (desc_ff.format)
         clf_pkg::FMT_FRAME:  rsp_byte_in = frame_byte(desc_ff, idx_ff);
         clf_pkg::FMT_SINGLE: rsp_byte_in = (idx_ff == '0) ? desc_ff.first_byte
                                                          : desc_ff.extra_byte;
         default:             rsp_byte_in = desc_ff.extra_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else if (load.valid) begin
         slot_valid_ff <= 1'b1;
         idx_ff        <= '0;
      end else if (advance) begin
         if (at_last) begin
            slot_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + clf_pkg::SINGLE_COUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         desc_ff <= load.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff  <= rsp_byte_in;
         rsp_kind_ff  <= desc_ff.kind;
         rsp_match_ff <= desc_ff.match;
         rsp_last_ff  <= at_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_match    = rsp_match_ff;
   assign rsp_last     = rsp_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_valid_ff |-> idx_ff < desc_ff.count)
      else $error("Result index has run past the end of the pending transaction.");

   a_single_results_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == clf_pkg::KIND_DATA
                       || rsp_kind_ff == clf_pkg::KIND_VERDICT) |-> rsp_last_ff)
      else $error("A data byte or verdict was not marked as the final result.");

   a_match_on_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_match_ff |-> rsp_kind_ff == clf_pkg::KIND_VERDICT)
      else $error("Match flag raised on a result that is not a verdict.");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> load_ready)
      else $error("A result set was loaded while the slot was still busy.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !slot_valid_ff && !rsp_valid_ff)
      else $error("Reset did not empty the result path.");

endmodule

>>> sim/tb_copier_link_command_framer_unit.sv
`timescale 1ns / 1ps

module tb_copier_link_command_framer_unit;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 400;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  code;
      logic [15:0] address;
      logic [15:0] length;
      logic [7:0]  value;
   } link_request_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       match;
      logic       last;
   } link_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = 2'd0;
   logic [7:0]  req_code = 8'd0;
   logic [15:0] req_address = 16'd0;
   logic [15:0] req_length = 16'd0;
   logic [7:0]  req_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_kind;
   logic        rsp_match;
   logic        rsp_last;

   link_request_type queued_requests[$];
   link_result_type  awaited_output[$];
   link_request_type staged_request;

   clf_pkg::phase_type link_phase;
   logic [15:0]        bytes_due;
   logic [7:0]         check_sum;
   logic [3:0]         low_nibble;
   logic               have_low_nibble;

   bit sending = 1'b0;
   bit request_taken = 1'b0;
   bit calm = 1'b0;
   bit draining = 1'b0;
   int calm_left = 0;
   int send_gap = 0;
   int sink_stall = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int useful_items = 0;

   copier_link_command_framer_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_code     (req_code),
      .req_address  (req_address),
      .req_length   (req_length),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_kind     (rsp_kind),
      .rsp_match    (rsp_match),
      .rsp_last     (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic logic [7:0] any_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   function automatic logic [15:0] any_word();
      logic [31:0] r;
      r = $urandom;
      return r[15:0];
   endfunction

   function automatic int draw_gap(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic link_result_type make_result(input logic [7:0] b, input logic [1:0] k,
                                                   input logic m);
      make_result = '{out_byte: b, kind: k, match: m, last: 1'b0};
   endfunction

   task automatic add_item(input logic [1:0] mode, input logic [7:0] code,
                           input logic [15:0] address, input logic [15:0] length,
                           input logic [7:0] value);
      link_request_type item;
      item = '{mode: mode, code: code, address: address, length: length, value: value};
      queued_requests.push_back(item);
   endtask

   task automatic add_nibbles(input logic [7:0] b);
      logic [3:0] junk;
      junk = 4'($urandom_range(0, 15));
      add_item(clf_pkg::MODE_NIBBLE, any_byte(), any_word(), any_word(), {junk, b[3:0]});
      junk = 4'($urandom_range(0, 15));
      add_item(clf_pkg::MODE_NIBBLE, any_byte(), any_word(), any_word(), {junk, b[7:4]});
   endtask

   task automatic run_link_framer(input link_request_type item);
      link_result_type burst [10];
      logic [7:0]      frame [9];
      logic [7:0]      b;
      int              n;
      n = 0;
      case (item.mode)
         clf_pkg::MODE_COMMAND: begin
            frame = '{clf_pkg::SYNC_FIRST, clf_pkg::SYNC_SECOND, clf_pkg::SYNC_THIRD,
                      item.code, item.address[7:0], item.address[15:8],
                      item.length[7:0], item.length[15:8],
                      clf_pkg::CHECK_SEED ^ item.code ^ item.address[7:0]
                         ^ item.address[15:8] ^ item.length[7:0] ^ item.length[15:8]};
            for (int i = 0; i < 9; i++) begin
               burst[n] = make_result(frame[i], clf_pkg::KIND_LINK, 1'b0);
               n = n + 1;
            end
            check_sum = clf_pkg::CHECK_SEED;
            bytes_due = item.length;
            low_nibble = 4'd0;
            have_low_nibble = 1'b0;
            if (item.code == clf_pkg::CMD_UPLOAD_A || item.code == clf_pkg::CMD_UPLOAD_B) begin
               if (item.length == 16'd0) begin
                  burst[n] = make_result(clf_pkg::CHECK_SEED, clf_pkg::KIND_LINK, 1'b0);
                  n = n + 1;
                  link_phase = clf_pkg::PHASE_IDLE;
               end else begin
                  link_phase = clf_pkg::PHASE_UPLOAD;
               end
            end else if (item.code == clf_pkg::CMD_DOWNLOAD_A
                         || item.code == clf_pkg::CMD_DOWNLOAD_B) begin
               link_phase = clf_pkg::PHASE_DOWNLOAD;
            end else begin
               link_phase = clf_pkg::PHASE_IDLE;
               bytes_due = 16'd0;
            end
         end
         clf_pkg::MODE_UPLOAD: begin
            if (link_phase == clf_pkg::PHASE_UPLOAD && bytes_due != 16'd0) begin
               burst[n] = make_result(item.value, clf_pkg::KIND_LINK, 1'b0);
               n = n + 1;
               check_sum = check_sum ^ item.value;
               bytes_due = bytes_due - 16'd1;
               if (bytes_due == 16'd0) begin
                  burst[n] = make_result(check_sum, clf_pkg::KIND_LINK, 1'b0);
                  n = n + 1;
                  link_phase = clf_pkg::PHASE_IDLE;
                  check_sum = clf_pkg::CHECK_SEED;
               end
            end
         end
         clf_pkg::MODE_NIBBLE: begin
            if (link_phase == clf_pkg::PHASE_DOWNLOAD) begin
               if (!have_low_nibble) begin
                  low_nibble = item.value[3:0] & clf_pkg::NIBBLE_MASK;
                  have_low_nibble = 1'b1;
               end else begin
                  b = {item.value[3:0] & clf_pkg::NIBBLE_MASK, low_nibble};
                  have_low_nibble = 1'b0;
                  low_nibble = 4'd0;
                  if (bytes_due != 16'd0) begin
                     burst[n] = make_result(b, clf_pkg::KIND_DATA, 1'b0);
                     n = n + 1;
                     check_sum = check_sum ^ b;
                     bytes_due = bytes_due - 16'd1;
                  end else begin
                     burst[n] = make_result(b, clf_pkg::KIND_VERDICT, b == check_sum);
                     n = n + 1;
                     link_phase = clf_pkg::PHASE_IDLE;
                     check_sum = clf_pkg::CHECK_SEED;
                  end
               end
            end
         end
         default: ;
      endcase
      if (n > 0) burst[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) awaited_output.push_back(burst[i]);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         sending = 1'b0;
         request_taken = 1'b0;
      end else begin
         if (request_taken) begin
            sending = 1'b0;
            request_taken = 1'b0;
         end
         if (!sending) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (queued_requests.size() != 0) begin
               staged_request = queued_requests.pop_front();
               req_mode <= staged_request.mode;
               req_code <= staged_request.code;
               req_address <= staged_request.address;
               req_length <= staged_request.length;
               req_value <= staged_request.value;
               sending = 1'b1;
               send_gap = draw_gap(calm);
            end
         end
         req_valid <= sending;
      end
   end

   always @(negedge clock) begin
      if (sink_stall > 0 && !draining) begin
         sink_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         sink_stall = draining ? 0 : draw_gap(calm);
      end
   end

   always @(posedge clock) begin
      link_result_type want;
      if (reset) begin
         link_phase = clf_pkg::PHASE_IDLE;
         bytes_due = 16'd0;
         check_sum = clf_pkg::CHECK_SEED;
         low_nibble = 4'd0;
         have_low_nibble = 1'b0;
      end else begin
         if (calm_left == 0) begin
            calm_left = $urandom_range(40, 250);
            calm = ($urandom_range(0, 3) == 0);
         end else begin
            calm_left--;
         end
         if (req_valid && req_ready) begin
            run_link_framer('{mode: req_mode, code: req_code, address: req_address,
                              length: req_length, value: req_value});
            request_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_output.size() == 0) begin
               $error("unexpected transaction: out_byte %h kind %0d match %0d last %0d",
                      rsp_out_byte, rsp_kind, rsp_match, rsp_last);
               mismatches++;
            end else begin
               want = awaited_output.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  mismatches++;
               end
               if (rsp_match !== want.match) begin
                  $error("match: expected %0d, got %0d", want.match, rsp_match);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("tb_copier_link_command_framer_unit: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      logic [7:0]  code;
      logic [7:0]  b;
      logic [7:0]  sum;
      logic [15:0] size;
      int          cut;
      int          pick;

      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'hFF);
      add_item(clf_pkg::MODE_UPLOAD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      add_item(MODE_IGNORED, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_UPLOAD_A, 16'hFFFF, 16'h0000, 8'h00);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_UPLOAD_B, 16'h1234, 16'h0002, 8'hFF);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'hFF);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'h00);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'h5A);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_DOWNLOAD_A, 16'h0000, 16'h0001, 8'h00);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'hFA);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'h05);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'h77);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'h3B);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'hCD);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_DOWNLOAD_B, 16'hFFFF, 16'h0000, 8'h00);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'h00);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'hF0);
      add_item(clf_pkg::MODE_COMMAND, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'h11);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_DOWNLOAD_A, 16'h8000, 16'h0003, 8'h00);
      add_item(clf_pkg::MODE_NIBBLE, 8'h00, 16'h0000, 16'h0000, 8'h07);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_UPLOAD_A, 16'h00FF, 16'hFFFF, 8'h00);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'h80);
      add_item(clf_pkg::MODE_COMMAND, clf_pkg::CMD_UPLOAD_B, 16'h0001, 16'h0001, 8'h00);
      add_item(clf_pkg::MODE_UPLOAD, 8'h00, 16'h0000, 16'h0000, 8'hAB);

      // Mostly well-formed transfers with random content; some are cut short by the
      // next command, and stray items of the wrong kind are sprinkled in.
      while (useful_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 24))
                                            : 16'($urandom_range(0, 6));
         cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, int'(size)) : int'(size);
         if (pick < 45) begin
            code = $urandom_range(0, 1) ? clf_pkg::CMD_UPLOAD_B : clf_pkg::CMD_UPLOAD_A;
            add_item(clf_pkg::MODE_COMMAND, code, any_word(), size, any_byte());
            useful_items++;
            for (int i = 0; i < cut; i++) begin
               if ($urandom_range(0, 9) == 0)
                  add_item(clf_pkg::MODE_NIBBLE, any_byte(), any_word(), any_word(),
                           any_byte());
               add_item(clf_pkg::MODE_UPLOAD, any_byte(), any_word(), any_word(), any_byte());
               useful_items++;
            end
            if ($urandom_range(0, 7) == 0)
               add_item(clf_pkg::MODE_UPLOAD, any_byte(), any_word(), any_word(), any_byte());
         end else if (pick < 85) begin
            code = $urandom_range(0, 1) ? clf_pkg::CMD_DOWNLOAD_B : clf_pkg::CMD_DOWNLOAD_A;
            add_item(clf_pkg::MODE_COMMAND, code, any_word(), size, any_byte());
            useful_items++;
            sum = clf_pkg::CHECK_SEED;
            for (int i = 0; i < cut; i++) begin
               if ($urandom_range(0, 9) == 0)
                  add_item(clf_pkg::MODE_UPLOAD, any_byte(), any_word(), any_word(),
                           any_byte());
               b = any_byte();
               sum = sum ^ b;
               add_nibbles(b);
               useful_items += 2;
            end
            if (cut == int'(size)) begin
               add_nibbles($urandom_range(0, 2) != 0 ? sum : any_byte());
               useful_items += 2;
            end else if ($urandom_range(0, 1) == 0) begin
               add_item(clf_pkg::MODE_NIBBLE, any_byte(), any_word(), any_word(), any_byte());
               useful_items++;
            end
         end else if (pick < 95) begin
            add_item(clf_pkg::MODE_COMMAND, any_byte(), any_word(), any_word(), any_byte());
            useful_items++;
         end else begin
            add_item(2'($urandom_range(1, 3)), any_byte(), any_word(), any_word(), any_byte());
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || sending) @(posedge clock);
      while (awaited_output.size() != 0) @(posedge clock);
      draining = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_copier_link_command_framer_unit: PASS");
      end else begin
         $display("tb_copier_link_command_framer_unit: FAIL");
      end
      $finish;
   end

endmodule
